### hdl/matrix_multiply_transposed_core_macros.svh
// Assertion macros for the A times B-transposed core.
// No dependencies; included by the top level only.
`ifndef MATRIX_MULTIPLY_TRANSPOSED_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_TRANSPOSED_CORE_MACROS_SVH

// same-cycle implication
`define MMT_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mmt: same-cycle check failed");

// next-cycle implication
`define MMT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mmt: next-cycle check failed");

`endif

### hdl/mmt_pkg.sv
// Shared widths, codes and types for the A times B-transposed core.
// No dependencies; used by the interfaces, the MAC, the top level and the bench.
package mmt_pkg;

  localparam int MODE_W      = 2;
  localparam int ROW_W       = 4;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int DOT_W       = 40;
  localparam int DIM_W       = 5;
  localparam int MAX_DIM_DEF = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;
  } mac_stat_t;

endpackage

### hdl/mmt_req_if.sv
// Request channel: element writes and dot-product queries.
// Depends on mmt_pkg.
interface mmt_req_if;
  logic                                valid;
  logic                                ready;
  logic [mmt_pkg::MODE_W-1:0]          mode;
  logic [mmt_pkg::ROW_W-1:0]           row;
  logic [mmt_pkg::ROW_W-1:0]           col;
  logic signed [mmt_pkg::VAL_W-1:0]    element_value;

  modport source (output valid, mode, row, col, element_value, input ready);
  modport sink   (input valid, mode, row, col, element_value, output ready);
endinterface

### hdl/mmt_rsp_if.sv
// Response channel: one C element per query.
// Depends on mmt_pkg.
interface mmt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmt_pkg::DOT_W-1:0]    dot_product;
  logic [mmt_pkg::ROW_W-1:0]           out_row;
  logic [mmt_pkg::ROW_W-1:0]           out_col;

  modport source (output valid, dot_product, out_row, out_col, input ready);
  modport sink   (input valid, dot_product, out_row, out_col, output ready);
endinterface

### hdl/mmt_store.sv
// Element store: one write port, one read port, registered read data.
// No dependencies.
module mmt_store #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/mmt_mac.sv
// Multiply-accumulate: aligns with store read latency, product reg, accumulator.
// Depends on mmt_pkg.
module mmt_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  mmt_pkg::mac_ctrl_t                ctrl,
  input  logic signed [mmt_pkg::VAL_W-1:0]  a,
  input  logic signed [mmt_pkg::VAL_W-1:0]  b,
  output logic signed [mmt_pkg::DOT_W-1:0]  acc,
  output mmt_pkg::mac_stat_t                stat
);

  logic                                rd_vld;
  logic                                rd_last;
  logic                                prod_vld;
  logic                                prod_last;
  logic signed [mmt_pkg::PROD_W-1:0]   prod;
  logic                                done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      prod_vld  <= 1'b0;
      prod_last <= 1'b0;
      done      <= 1'b0;
    end else begin
      rd_vld    <= ctrl.issue;
      rd_last   <= ctrl.issue & ctrl.last;
      prod_vld  <= rd_vld;
      prod_last <= rd_last;
      done      <= prod_vld & prod_last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + mmt_pkg::DOT_W'(prod);
    end
  end

  assign stat.done = done;

endmodule

### hdl/matrix_multiply_transposed_core.sv
// Top level of the A times B-transposed core: control, element stores, MAC.
// Depends on mmt_pkg, mmt_req_if, mmt_rsp_if, mmt_store, mmt_mac and the macro header.
//
// Usage:
//   req carries words with mode write-A, write-B or query, a row, a col and a
//   signed Q8.8 element_value. Writes store one element and give no response;
//   mode 3 is taken and dropped. A query returns one rsp word: the Q24.16 dot
//   product of A row `row` and B row `col` over the dimension in use, with the
//   row and col echoed (product zero when either is outside the dimension).
//   cfg_we/cfg_data load the dimension (reset 16, saturates at MAX_DIM);
//   change it only while idle.
// Timing:
//   Writes can be taken every cycle while no query is in flight.
//   A query walks n = dimension elements through one store read port per
//   matrix and one multiplier, one element a cycle, then waits for the MAC to
//   drain (an out-of-range query skips the walk); rsp.valid rises and
//   req.ready returns in the same cycle. One query is in flight at a time.
//   The response sits in an output register, so writes and the next query
//   proceed while rsp is stalled; a finished query waits only if that
//   register is still full.
// Reset: synchronous rst clears control and sets the dimension to 16; store
//   contents stay undefined until written.
`include "matrix_multiply_transposed_core_macros.svh"

module matrix_multiply_transposed_core #(
  parameter int MAX_DIM = mmt_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mmt_pkg::DIM_W-1:0]   cfg_data,
  mmt_req_if.sink                     req,
  mmt_rsp_if.source                   rsp
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int NW     = (IDX_W + 1 > mmt_pkg::DIM_W) ? IDX_W + 1 : mmt_pkg::DIM_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_DIM);

  mmt_pkg::state_t                   state, state_next;
  logic [IDX_W-1:0]                  k, k_next;
  logic [mmt_pkg::DIM_W-1:0]         dimension;
  logic [mmt_pkg::ROW_W-1:0]         q_row, q_col;
  logic                              out_valid;
  logic signed [mmt_pkg::DOT_W-1:0]  out_dot;
  logic [mmt_pkg::ROW_W-1:0]         out_row_q, out_col_q;

  logic [NW-1:0]      dim_ext, n_used;
  logic [NW-1:0]      row_ext, col_ext, q_row_ext, q_col_ext;
  logic               req_acc, is_write, is_query, wr_in_store, q_in_range;
  logic               k_last, out_load, mem_we;
  logic [ADDR_W-1:0]  waddr, a_raddr, b_raddr;
  logic [mmt_pkg::VAL_W-1:0]         a_rdata, b_rdata;
  logic signed [mmt_pkg::DOT_W-1:0]  acc;
  mmt_pkg::mac_ctrl_t                mac_ctrl;
  mmt_pkg::mac_stat_t                mac_stat;

  assign dim_ext   = NW'(dimension);
  assign n_used    = (dim_ext > MAX_N) ? MAX_N : dim_ext;
  assign row_ext   = NW'(req.row);
  assign col_ext   = NW'(req.col);
  assign q_row_ext = NW'(q_row);
  assign q_col_ext = NW'(q_col);

  assign req.ready   = (state == mmt_pkg::ST_IDLE);
  assign req_acc     = req.valid & req.ready;
  assign is_write    = (req.mode == mmt_pkg::MODE_WRITE_A) || (req.mode == mmt_pkg::MODE_WRITE_B);
  assign is_query    = (req.mode == mmt_pkg::MODE_QUERY);
  assign wr_in_store = (row_ext < MAX_N) && (col_ext < MAX_N);
  assign q_in_range  = (row_ext < n_used) && (col_ext < n_used);
  assign mem_we      = req_acc & is_write & wr_in_store;

  assign waddr   = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};
  assign a_raddr = {q_row_ext[IDX_W-1:0], k};
  assign b_raddr = {q_col_ext[IDX_W-1:0], k};

  assign k_last   = (NW'(k) == n_used - NW'(1));
  assign out_load = (state == mmt_pkg::ST_FINISH) && (!out_valid || rsp.ready);

  assign mac_ctrl.clear = req_acc & is_query;
  assign mac_ctrl.issue = (state == mmt_pkg::ST_RUN);
  assign mac_ctrl.last  = k_last;

  mmt_store #(.ADDR_W(ADDR_W), .DATA_W(mmt_pkg::VAL_W)) u_store_a (
    .clk   (clk),
    .we    (mem_we && (req.mode == mmt_pkg::MODE_WRITE_A)),
    .waddr (waddr),
    .wdata (req.element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmt_store #(.ADDR_W(ADDR_W), .DATA_W(mmt_pkg::VAL_W)) u_store_b (
    .clk   (clk),
    .we    (mem_we && (req.mode == mmt_pkg::MODE_WRITE_B)),
    .waddr (waddr),
    .wdata (req.element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mmt_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    ($signed(a_rdata)),
    .b    ($signed(b_rdata)),
    .acc  (acc),
    .stat (mac_stat)
  );

  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      mmt_pkg::ST_IDLE: begin
        k_next = '0;
        if (req_acc && is_query) begin
          state_next = q_in_range ? mmt_pkg::ST_RUN : mmt_pkg::ST_FINISH;
        end
      end
      mmt_pkg::ST_RUN: begin
        k_next = k + IDX_W'(1);
        if (k_last) begin
          state_next = mmt_pkg::ST_WAIT;
        end
      end
      mmt_pkg::ST_WAIT: begin
        if (mac_stat.done) begin
          state_next = mmt_pkg::ST_FINISH;
        end
      end
      mmt_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = mmt_pkg::ST_IDLE;
        end
      end
      default: state_next = mmt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mmt_pkg::ST_IDLE;
      k         <= '0;
      dimension <= mmt_pkg::DIM_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (cfg_we) begin
        dimension <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && is_query) begin
      q_row <= req.row;
      q_col <= req.col;
    end
    if (out_load) begin
      out_dot   <= acc;
      out_row_q <= q_row;
      out_col_q <= q_col;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.dot_product = out_dot;
  assign rsp.out_row     = out_row_q;
  assign rsp.out_col     = out_col_q;

  `MMT_ASSERT_SAME(a_no_write_busy, clk, rst, state != mmt_pkg::ST_IDLE, !mem_we)
  `MMT_ASSERT_SAME(a_done_in_wait, clk, rst, mac_stat.done, state == mmt_pkg::ST_WAIT)
  `MMT_ASSERT_SAME(a_k_bounded, clk, rst, state == mmt_pkg::ST_RUN, NW'(k) < n_used)
  `MMT_ASSERT_NEXT(a_finish_loads, clk, rst, out_load, out_valid && state == mmt_pkg::ST_IDLE)

endmodule

### tb/testbench.sv
// Self-checking bench for matrix_multiply_transposed_core (C = A * B^T, Q8.8 in, Q24.16 out).
// Needs mmt_pkg, mmt_req_if, mmt_rsp_if and the core. A scoreboard class tracks both
// element stores and the dimension, and predicts each queried dot product.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_DIM = mmt_pkg::MAX_DIM_DEF;
  localparam logic [mmt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 130;
  localparam int PRESSURE_PHASE = 1;

  typedef struct {
    logic signed [mmt_pkg::DOT_W-1:0] dot;
    logic [mmt_pkg::ROW_W-1:0]        row;
    logic [mmt_pkg::ROW_W-1:0]        col;
  } dot_want_t;

  class dot_product_tracker;
    logic signed [mmt_pkg::VAL_W-1:0] a_store [MAX_DIM][MAX_DIM];
    logic signed [mmt_pkg::VAL_W-1:0] b_store [MAX_DIM][MAX_DIM];
    bit                               a_set [MAX_DIM][MAX_DIM];
    bit                               b_set [MAX_DIM][MAX_DIM];
    logic [mmt_pkg::DIM_W-1:0]        dim_reg;
    dot_want_t                        pending_dots [$];
    int                               fault_count;

    function new();
      dim_reg = mmt_pkg::DIM_RESET;
      fault_count = 0;
    endfunction

    function void set_dimension(logic [mmt_pkg::DIM_W-1:0] d);
      dim_reg = d;
    endfunction

    function int used_dim();
      return (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    endfunction

    function logic signed [mmt_pkg::DOT_W-1:0] dot_of(int r, int c);
      longint acc;
      int     n;
      acc = 0;
      n = used_dim();
      if (r < n && c < n) begin
        for (int k = 0; k < n; k++)
          acc += longint'(a_store[r][k]) * longint'(b_store[c][k]);
      end
      return acc[mmt_pkg::DOT_W-1:0];
    endfunction

    function void accept_word(logic [mmt_pkg::MODE_W-1:0] mode,
                              logic [mmt_pkg::ROW_W-1:0] row,
                              logic [mmt_pkg::ROW_W-1:0] col,
                              logic signed [mmt_pkg::VAL_W-1:0] val);
      dot_want_t w;
      case (mode)
        mmt_pkg::MODE_WRITE_A: begin
          a_store[row][col] = val;
          a_set[row][col] = 1'b1;
        end
        mmt_pkg::MODE_WRITE_B: begin
          b_store[row][col] = val;
          b_set[row][col] = 1'b1;
        end
        mmt_pkg::MODE_QUERY: begin
          w.dot = dot_of(row, col);
          w.row = row;
          w.col = col;
          pending_dots.push_back(w);
        end
        default: ;
      endcase
    endfunction

    function void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
    endfunction

    function void check_word(logic signed [mmt_pkg::DOT_W-1:0] dot,
                             logic [mmt_pkg::ROW_W-1:0] row,
                             logic [mmt_pkg::ROW_W-1:0] col);
      dot_want_t w;
      if (pending_dots.size() == 0) begin
        note_fault($sformatf("unexpected word: dot %0d row %0d col %0d", dot, row, col));
        return;
      end
      w = pending_dots.pop_front();
      if (dot !== w.dot || row !== w.row || col !== w.col)
        note_fault($sformatf("mismatch: want dot %0d row %0d col %0d, got dot %0d row %0d col %0d",
                             w.dot, w.row, w.col, dot, row, col));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [mmt_pkg::DIM_W-1:0] cfg_data;

  mmt_req_if req_bus ();
  mmt_rsp_if rsp_bus ();

  matrix_multiply_transposed_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  dot_product_tracker sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int hold_ask;
  int hold_seen;
  int hold_left;
  int stall_cycles;

  int send_pct_tab [4] = '{0, 84, 0, 32};
  int recv_pct_tab [4] = '{0, 0, 84, 32};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: checks results, drives ready, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_word(rsp_bus.dot_product, rsp_bus.out_row, rsp_bus.out_col);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [mmt_pkg::VAL_W-1:0] pick_value();
    logic [mmt_pkg::VAL_W-1:0] corners [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                                16'h0001};
    if ($urandom_range(3) == 0) return corners[$urandom_range(4)];
    return mmt_pkg::VAL_W'($urandom_range(16'hFFFF));
  endfunction

  task automatic push_word(input logic [mmt_pkg::MODE_W-1:0] mode, input int row,
                           input int col, input logic [mmt_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.mode          <= mode;
    req_bus.row           <= mmt_pkg::ROW_W'(row);
    req_bus.col           <= mmt_pkg::ROW_W'(col);
    req_bus.element_value <= val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.accept_word(mode, mmt_pkg::ROW_W'(row), mmt_pkg::ROW_W'(col), val);
    words_sent++;
  endtask

  task automatic load_dimension(input int d);
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mmt_pkg::DIM_W'(d);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_dimension(mmt_pkg::DIM_W'(d));
  endtask

  // fill the needed rows where unwritten (plus some rewrites), then query; out-of-range queries skip the fill
  task automatic run_query_job();
    int n;
    int r;
    int c;
    int t;
    n = sb.used_dim();
    if (n == 0) begin
      r = $urandom_range(15);
      c = $urandom_range(15);
    end else if (n < MAX_DIM && $urandom_range(9) == 0) begin
      r = $urandom_range(15);
      c = (r >= n) ? $urandom_range(15) : $urandom_range(15, n);
      if ($urandom_range(1)) begin
        t = r;
        r = c;
        c = t;
      end
    end else begin
      r = $urandom_range(n - 1);
      c = $urandom_range(n - 1);
      for (int k = 0; k < n; k++)
        if (!sb.a_set[r][k] || $urandom_range(7) == 0)
          push_word(mmt_pkg::MODE_WRITE_A, r, k, pick_value());
      for (int k = 0; k < n; k++)
        if (!sb.b_set[c][k] || $urandom_range(7) == 0)
          push_word(mmt_pkg::MODE_WRITE_B, c, k, pick_value());
    end
    push_word(mmt_pkg::MODE_QUERY, r, c, mmt_pkg::VAL_W'($urandom_range(16'hFFFF)));
  endtask

  task automatic run_noise_word();
    case ($urandom_range(3))
      0: push_word(MODE_UNUSED, $urandom_range(15), $urandom_range(15), pick_value());
      1: push_word(mmt_pkg::MODE_WRITE_A, $urandom_range(15), $urandom_range(15),
                   pick_value());
      default: push_word(mmt_pkg::MODE_WRITE_B, $urandom_range(15), $urandom_range(15),
                         pick_value());
    endcase
  endtask

  task automatic run_directed();
    load_dimension(1);
    push_word(mmt_pkg::MODE_WRITE_A, 0, 0, 16'h7FFF);
    push_word(mmt_pkg::MODE_WRITE_B, 0, 0, 16'h7FFF);
    push_word(mmt_pkg::MODE_QUERY, 0, 0, 16'h5A5A);
    push_word(mmt_pkg::MODE_WRITE_A, 0, 0, 16'h8000);
    push_word(mmt_pkg::MODE_WRITE_B, 0, 0, 16'h8000);
    push_word(mmt_pkg::MODE_QUERY, 0, 0, 16'h0000);
    push_word(mmt_pkg::MODE_WRITE_B, 0, 0, 16'h7FFF);
    push_word(mmt_pkg::MODE_QUERY, 0, 0, 16'hFFFF);
    push_word(MODE_UNUSED, 15, 15, 16'hFFFF);
    push_word(MODE_UNUSED, 0, 0, 16'h0000);
    push_word(mmt_pkg::MODE_QUERY, 15, 15, 16'h0000);
    push_word(mmt_pkg::MODE_QUERY, 0, 15, 16'hFFFF);
    push_word(mmt_pkg::MODE_QUERY, 15, 0, 16'h0000);
    push_word(mmt_pkg::MODE_WRITE_A, 15, 15, 16'h8000);
    push_word(mmt_pkg::MODE_WRITE_B, 15, 15, 16'h0001);
    push_word(mmt_pkg::MODE_WRITE_A, 0, 0, 16'h0000);
    push_word(mmt_pkg::MODE_QUERY, 0, 0, 16'h0000);
    load_dimension(0);
    push_word(mmt_pkg::MODE_QUERY, 0, 0, 16'hFFFF);
    push_word(mmt_pkg::MODE_QUERY, 15, 15, 16'h0000);
  endtask

  initial begin
    int dim_plan [10] = '{16, 2, 31, 1, 17, 0, 8, -1, 16, -1};
    int phase_start;
    int mode_start;
    int idle_mode;

    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_data              <= '0;
    req_bus.valid         <= 1'b0;
    req_bus.mode          <= mmt_pkg::MODE_WRITE_A;
    req_bus.row           <= '0;
    req_bus.col           <= '0;
    req_bus.element_value <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_sent = 0;
    hold_ask = 0;
    hold_seen = 0;
    hold_left = 0;
    idle_mode = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    foreach (dim_plan[p]) begin
      load_dimension((dim_plan[p] < 0) ? $urandom_range(1, 31) : dim_plan[p]);
      if (p == PRESSURE_PHASE) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_ask++;
        repeat (24) run_query_job();
      end
      phase_start = words_sent;
      mode_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        if (words_sent - mode_start >= 30) begin
          idle_mode = (idle_mode + 1) % 4;
          mode_start = words_sent;
        end
        send_idle_pct = send_pct_tab[idle_mode];
        recv_stall_pct = recv_pct_tab[idle_mode];
        if ($urandom_range(99) < 15) run_noise_word();
        else run_query_job();
      end
    end

    req_bus.valid <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (sb.pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fault_count == 0 && sb.pending_dots.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
